// ===== rtl/core/gpm_pkg.sv =====
package gpm_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned GainW  = 9;
  localparam int unsigned Lanes  = 4;
  localparam int unsigned WordW  = ByteW * Lanes;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegLeftGain   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRightGain  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPixelFormat = 2'd2;

  localparam logic [GainW-1:0] GainUnity = 9'd256;

  typedef enum logic {
    FMT_RGBA = 1'b0,
    FMT_UYVY = 1'b1
  } pixel_format_t;

  // What one byte lane computes
  typedef enum logic [1:0] {
    LANE_COLOR  = 2'd0,
    LANE_ALPHA  = 2'd1,
    LANE_LUMA   = 2'd2,
    LANE_CHROMA = 2'd3
  } lane_mode_t;

  typedef struct packed {
    logic [GainW-1:0] left_gain;
    logic [GainW-1:0] right_gain;
  } gain_cfg_t;

endpackage

// ===== rtl/core/gpm_lane.sv =====
module gpm_lane
  import gpm_pkg::*;
(
  input  lane_mode_t       mode,
  input  gain_cfg_t        gains,
  input  logic [ByteW-1:0] left_byte,
  input  logic [ByteW-1:0] right_byte,
  output logic [ByteW-1:0] mixed_byte
);

  // Unsigned scaling for color and luma
  logic [ByteW+GainW-1:0] left_prod;
  logic [ByteW+GainW-1:0] right_prod;
  // Chroma: byte offset around 128, times gain, floor shift
  logic signed [ByteW-1:0]  left_off;
  logic signed [ByteW-1:0]  right_off;
  logic signed [GainW:0]    left_sgain;
  logic signed [GainW:0]    right_sgain;
  logic signed [ByteW+GainW:0] left_cprod;
  logic signed [ByteW+GainW:0] right_cprod;
  logic signed [10:0] left_chroma;
  logic signed [10:0] right_chroma;
  logic signed [11:0] chroma_sum;
  logic [8:0] color_sum;
  logic [9:0] luma_sum;

  assign left_prod  = {{GainW{1'b0}}, left_byte} * {{ByteW{1'b0}}, gains.left_gain};
  assign right_prod = {{GainW{1'b0}}, right_byte} * {{ByteW{1'b0}}, gains.right_gain};

  // x - 128 is the byte with its top bit flipped, read as signed
  assign left_off    = $signed({~left_byte[ByteW-1], left_byte[ByteW-2:0]});
  assign right_off   = $signed({~right_byte[ByteW-1], right_byte[ByteW-2:0]});
  assign left_sgain  = $signed({1'b0, gains.left_gain});
  assign right_sgain = $signed({1'b0, gains.right_gain});
  assign left_cprod  = {{(GainW+1){left_off[ByteW-1]}}, left_off} * left_sgain;
  assign right_cprod = {{(GainW+1){right_off[ByteW-1]}}, right_off} * right_sgain;

  // Arithmetic shift right eight, then re-center on 128
  assign left_chroma  = {left_cprod[ByteW+GainW], left_cprod[ByteW+GainW:ByteW]}
                        + 11'sd128;
  assign right_chroma = {right_cprod[ByteW+GainW], right_cprod[ByteW+GainW:ByteW]}
                        + 11'sd128;
  assign chroma_sum   = {left_chroma[10], left_chroma}
                        + {right_chroma, 1'b0} - 12'sd255;

  // Color keeps only the low 8 bits of each scaled value
  assign color_sum = {1'b0, left_prod[2*ByteW-1:ByteW]}
                   + {1'b0, right_prod[2*ByteW-1:ByteW]};
  assign luma_sum  = {1'b0, left_prod[ByteW+GainW-1:ByteW]}
                   + {1'b0, right_prod[ByteW+GainW-1:ByteW]};

  // Saturate per lane mode
  always_comb begin
    unique case (mode)
      LANE_COLOR:  mixed_byte = color_sum[8] ? 8'hFF : color_sum[7:0];
      LANE_ALPHA:  mixed_byte = left_byte;
      LANE_LUMA:   mixed_byte = (luma_sum[9:8] != 2'b00) ? 8'hFF : luma_sum[7:0];
      LANE_CHROMA: begin
        if (chroma_sum[11]) begin
          mixed_byte = 8'h00;
        end else if (chroma_sum[10:8] != 3'b000) begin
          mixed_byte = 8'hFF;
        end else begin
          mixed_byte = chroma_sum[7:0];
        end
      end
      default:     mixed_byte = left_byte;
    endcase
  end

endmodule

// ===== rtl/core/gained_pixel_mixer.sv =====
// Gained pixel mixer: blend of two 32-bit pixel words in packed RGBA or
// UYVY layout; color and luma bytes scaled by their gain ((x * gain) >> 8,
// 256 is unity) and summed with saturation, alpha from the left word.
//
// Input channel: in_valid / in_stall with left_word and right_word. A
// transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with mixed_word, same rule.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 left gain, 1 right gain, 2 pixel format (0 RGBA, 1 UYVY).
// cfg_ready is always high. Write registers only while the block is empty.
//
// A word passes through two registers, the input register and the result
// register, with all byte math in between; out_valid rises when the result
// register takes it. Throughput is one word per cycle while out_stall is
// low. When out_stall holds the result register, one more word waits in
// the input register and in_stall rises after that.
// Reset (rst, synchronous) empties both registers and sets both gains to
// 256 and the format to RGBA.
module gained_pixel_mixer
  import gpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WordW-1:0]     left_word,
  input  logic [WordW-1:0]     right_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WordW-1:0]     mixed_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [GainW-1:0]     cfg_data
);

  gain_cfg_t      gains;
  pixel_format_t  pixel_format;

  logic             s1_valid;
  logic [WordW-1:0] s1_left;
  logic [WordW-1:0] s1_right;
  logic             advance;
  logic [WordW-1:0] mixed_next;
  lane_mode_t       lane_mode [Lanes];

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.left_gain  <= GainUnity;
      gains.right_gain <= GainUnity;
      pixel_format     <= FMT_RGBA;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegLeftGain:    gains.left_gain  <= cfg_data;
        RegRightGain:   gains.right_gain <= cfg_data;
        RegPixelFormat: pixel_format     <= pixel_format_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // Advance when the result register is empty or being drained
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // Hold the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_left  <= left_word;
      s1_right <= right_word;
    end
  end

  // Pick the job of each byte lane
  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      if (pixel_format == FMT_UYVY) begin
        lane_mode[k] = (k % 2 == 0) ? LANE_CHROMA : LANE_LUMA;
      end else begin
        lane_mode[k] = (k == Lanes - 1) ? LANE_ALPHA : LANE_COLOR;
      end
    end
  end

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    gpm_lane u_lane (
      .mode       (lane_mode[k]),
      .gains      (gains),
      .left_byte  (s1_left[k*ByteW +: ByteW]),
      .right_byte (s1_right[k*ByteW +: ByteW]),
      .mixed_byte (mixed_next[k*ByteW +: ByteW])
    );
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mixed_word <= mixed_next;
    end
  end

endmodule

// ===== rtl/core/gpm_checker.sv =====
module gpm_checker
  import gpm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [WordW-1:0]   mixed_word
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // Stall back only when the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // A transfer reaches the result register when the output is not blocked
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted word did not reach the output");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(mixed_word)))
    else $error("stalled result changed");

endmodule

bind gained_pixel_mixer gpm_checker u_gpm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .mixed_word (mixed_word)
);

// ===== tb/sv/gained_pixel_mixer_test.sv =====
`timescale 1ns / 1ps

module gained_pixel_mixer_test;
  import gpm_pkg::*;

  typedef logic [WordW-1:0] word_t;
  typedef logic [GainW-1:0] gain_t;

  // Index past the last register: a write there must change nothing
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int RandPhases = 13;
  localparam int PhaseWords = 50;
  localparam int DirectedRows = 20;

  // One directed transfer and the settings it runs under
  typedef struct packed {
    gain_t         gain_l;
    gain_t         gain_r;
    pixel_format_t fmt;
    word_t         left;
    word_t         right;
    logic          known;
    word_t         want;
  } stim_row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  word_t         left_word;
  word_t         right_word;
  logic          out_valid;
  logic          out_stall;
  word_t         mixed_word;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  gain_t         cfg_data;

  // Settings as the block should hold them
  gain_t         left_gain_now;
  gain_t         right_gain_now;
  pixel_format_t format_now;

  word_t         predicted_words[$];
  int            mismatches;
  bit            in_calm;
  bit            out_calm;
  bit            word_taken;
  int            out_hold;
  word_t         due_word;

  stim_row_t stim_rows [0:DirectedRows-1] = '{
    // reset settings: unity gains, RGBA
    '{9'd256, 9'd256, FMT_RGBA, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{9'd256, 9'd256, FMT_RGBA, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{9'd256, 9'd256, FMT_RGBA, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00FFFFFF},
    '{9'd256, 9'd256, FMT_RGBA, 32'hAB000000, 32'hCD000000, 1'b1, 32'hAB000000},
    '{9'd256, 9'd256, FMT_RGBA, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h0},
    '{9'd256, 9'd256, FMT_RGBA, 32'h00402010, 32'h00010203, 1'b0, 32'h0},
    // zero gains keep only alpha
    '{9'd0,   9'd0,   FMT_RGBA, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFF000000},
    // top gains: scaled bytes wrap to eight bits
    '{9'd511, 9'd511, FMT_RGBA, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{9'd511, 9'd0,   FMT_RGBA, 32'h80808080, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{9'd511, 9'd511, FMT_RGBA, 32'h01010101, 32'h01010101, 1'b0, 32'h0},
    '{9'd384, 9'd128, FMT_RGBA, 32'h7F7F7F7F, 32'h81818181, 1'b0, 32'h0},
    // UYVY at unity: chroma floor and both clamps
    '{9'd256, 9'd256, FMT_UYVY, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    '{9'd256, 9'd256, FMT_UYVY, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{9'd256, 9'd256, FMT_UYVY, 32'h80808080, 32'h80808080, 1'b1, 32'hFF81FF81},
    '{9'd256, 9'd256, FMT_UYVY, 32'h807F8081, 32'h7F80817F, 1'b0, 32'h0},
    // zero gains pin chroma at 0x81 and luma at zero
    '{9'd0,   9'd0,   FMT_UYVY, 32'h12345678, 32'h9ABCDEF0, 1'b1, 32'h00810081},
    '{9'd511, 9'd511, FMT_UYVY, 32'hFF00FF00, 32'h00FF00FF, 1'b0, 32'h0},
    '{9'd511, 9'd511, FMT_UYVY, 32'h00FF00FF, 32'hFF00FF00, 1'b0, 32'h0},
    '{9'd1,   9'd511, FMT_UYVY, 32'h00000000, 32'h00000000, 1'b0, 32'h0},
    '{9'd511, 9'd1,   FMT_UYVY, 32'h7F7F7F7F, 32'h7F7F7F7F, 1'b0, 32'h0}
  };

  gained_pixel_mixer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_word  (left_word),
    .right_word (right_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mixed_word (mixed_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int sat_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Chroma offset around the midpoint, floor shift on negative products
  function automatic int chroma_gained(input logic [7:0] x, input gain_t g);
    int p;
    p = (int'(x) - 128) * int'(g);
    return (p >>> 8) + 128;
  endfunction

  // Mixed word for the current gains and format
  function automatic word_t mix_pixels(input word_t l, input word_t r);
    word_t out;
    int a;
    int b;
    out = '0;
    if (format_now == FMT_RGBA) begin
      out[31:24] = l[31:24];
      for (int k = 0; k < 3; k++) begin
        a = ((int'(l[8*k +: 8]) * int'(left_gain_now)) >> 8) & 255;
        b = ((int'(r[8*k +: 8]) * int'(right_gain_now)) >> 8) & 255;
        out[8*k +: 8] = 8'(sat_byte(a + b));
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (k % 2 == 0) begin
          a = chroma_gained(l[8*k +: 8], left_gain_now);
          b = chroma_gained(r[8*k +: 8], right_gain_now);
          out[8*k +: 8] = 8'(sat_byte(a + 2 * b - 255));
        end else begin
          a = (int'(l[8*k +: 8]) * int'(left_gain_now)) >> 8;
          b = (int'(r[8*k +: 8]) * int'(right_gain_now)) >> 8;
          out[8*k +: 8] = 8'(sat_byte(a + b));
        end
      end
    end
    return out;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    if (mismatches < 40) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic word_t rand_word();
    logic [7:0] corner [7] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
    word_t w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < 4; k++) w[8*k +: 8] = corner[$urandom_range(0, 6)];
      1: for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 1) == 0) w[8*k +: 8] = corner[$urandom_range(0, 6)];
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 11))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd255;
      3: return GainUnity;
      4: return 9'd257;
      5: return 9'd511;
      default: return gain_t'($urandom_range(0, 511));
    endcase
  endfunction

  // Write one register and track it on the transfer
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input gain_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegLeftGain:    left_gain_now = data;
      RegRightGain:   right_gain_now = data;
      RegPixelFormat: format_now = pixel_format_t'(data[0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid and hold until every predicted word has come out
  task automatic drain_words();
    @(negedge clk);
    in_valid = 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input gain_t gl, input gain_t gr, input logic fmt_bit,
                                input bit spare_write);
    drain_words();
    write_reg(RegLeftGain, gl);
    write_reg(RegRightGain, gr);
    write_reg(RegPixelFormat, {gain_t'($urandom_range(0, 255)) << 1} | gain_t'(fmt_bit));
    if (spare_write) write_reg(RegSpare, gain_t'($urandom_range(0, 511)));
  endtask

  // Offer one word pair after a random gap (none when in_calm); valid stays high after the transfer
  task automatic send_pair(input word_t l, input word_t r, input logic known,
                           input word_t want);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    left_word  = l;
    right_word = r;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted_words.push_back(known ? want : mix_pixels(l, r));
  endtask

  // Check each transfer against the oldest prediction
  always @(posedge clk) begin
    word_taken = !rst && out_valid && !out_stall;
    if (word_taken) begin
      if (predicted_words.size() == 0) begin
        report_mismatch("unexpected word", mixed_word, '0);
      end else begin
        due_word = predicted_words.pop_front();
        if (mixed_word !== due_word) report_mismatch("mixed_word", mixed_word, due_word);
      end
    end
  end

  // Hold the result side for a drawn number of cycles after each transfer
  always @(negedge clk) begin
    if (word_taken) out_hold = out_calm ? 0 : $urandom_range(0, 11);
    if (out_hold > 0) begin
      out_stall = 1'b1;
      out_hold--;
    end else begin
      out_stall = 1'b0;
    end
  end

  initial begin
    stim_row_t row;
    gain_t gl;
    gain_t gr;
    logic fmt_bit;
    rst            = 1'b1;
    in_valid       = 1'b0;
    left_word      = '0;
    right_word     = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = RegLeftGain;
    cfg_data       = '0;
    left_gain_now  = GainUnity;
    right_gain_now = GainUnity;
    format_now     = FMT_RGBA;
    mismatches     = 0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    word_taken     = 1'b0;
    out_hold       = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows; settings change only with the pipeline empty
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.gain_l != left_gain_now || row.gain_r != right_gain_now ||
          row.fmt != format_now) begin
        apply_settings(row.gain_l, row.gain_r, row.fmt, 1'b0);
      end
      send_pair(row.left, row.right, row.known, row.want);
    end

    // Random phases, each under its own gains and format
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin gl = 9'd511; gr = 9'd0; end
        1: begin gl = 9'd0; gr = 9'd511; end
        default: begin gl = pick_gain(); gr = pick_gain(); end
      endcase
      fmt_bit = (ph < 4) ? ph[0] : logic'($urandom_range(0, 1));
      apply_settings(gl, gr, fmt_bit, ph == 0 || $urandom_range(0, 3) == 0);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseWords; n++) begin
        send_pair(rand_word(), rand_word(), 1'b0, '0);
      end
    end

    drain_words();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
